@@ hw/rtl/neighbor_reachability_watcher_top_assert.svh @@
// Assertion macros for the watcher RTL, included by nrw_core.
`ifndef NEIGHBOR_REACHABILITY_WATCHER_TOP_ASSERT_SVH
`define NEIGHBOR_REACHABILITY_WATCHER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (active low).
`define NRW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nrw assertion failed");
// Clocked check that also holds during reset.
`define NRW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nrw assertion failed");
`else
`define NRW_ASSERT(lbl, clk, rstn, prop)
`define NRW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hw/rtl/nrw_pkg.sv @@
package nrw_pkg;

    typedef enum logic [2:0] {
        WS_UNKNOWN  = 3'd0,
        WS_REACH    = 3'd1,
        WS_REACH_Q  = 3'd2,
        WS_UNREACH  = 3'd3,
        WS_LINKUP_Q = 3'd4
    } watch_state_t;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_CREATE     = 3'd1,
        ACT_LINK_UP    = 3'd2,
        ACT_LINK_DOWN  = 3'd3,
        ACT_FORCE      = 3'd4,
        ACT_PROBE_OK   = 3'd5,
        ACT_PROBE_FAIL = 3'd6,
        ACT_RELEASE    = 3'd7
    } action_t;

    localparam int unsigned PERIOD_W         = 24;
    localparam int unsigned DEFAULT_SECONDS  = 120;
    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam logic [PERIOD_W-1:0] RECHECK_TICKS_RESET =
        PERIOD_W'(DEFAULT_SECONDS * TICKS_PER_SECOND);

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_PERIODIC_ENABLE = 1'b0;
    localparam logic REG_RECHECK_TICKS   = 1'b1;

    typedef struct packed {
        logic                periodic_enable;
        logic [PERIOD_W-1:0] recheck_ticks;
    } nrw_cfg_t;

    typedef struct packed {
        watch_state_t state_now;
        logic         reachable_now;
        logic         router_now;
        logic         notify_reachable;
        logic         after_link_up;
        logic         notify_unreachable;
        logic         notify_permanent_loss;
        logic         notify_router_change;
        logic         start_probe;
        logic         cancel_probe;
    } nrw_result_t;

endpackage

@@ hw/rtl/nrw_apb.sv @@
module nrw_apb (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nrw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [nrw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [nrw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output nrw_pkg::nrw_cfg_t                   cfg
);
    import nrw_pkg::*;

    logic                periodic_enable_reg;
    logic [PERIOD_W-1:0] recheck_ticks_reg;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            periodic_enable_reg <= 1'b0;
            recheck_ticks_reg   <= RECHECK_TICKS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PERIODIC_ENABLE: periodic_enable_reg <= pwdata[0];
                REG_RECHECK_TICKS:   recheck_ticks_reg   <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PERIODIC_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, periodic_enable_reg};
            REG_RECHECK_TICKS:   prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, recheck_ticks_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.periodic_enable = periodic_enable_reg;
    assign cfg.recheck_ticks   = recheck_ticks_reg;

endmodule

@@ hw/rtl/nrw_core.sv @@
module nrw_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  nrw_pkg::action_t     act,
    input  logic                 is_router,
    input  nrw_pkg::nrw_cfg_t    cfg,
    output nrw_pkg::nrw_result_t result
);
    import nrw_pkg::*;

    `include "neighbor_reachability_watcher_top_assert.svh"

    watch_state_t        state_reg, state_next;
    logic                router_reg, router_next;
    logic                run_reg, run_next;
    logic [PERIOD_W-1:0] count_reg, count_next;

    logic querying;
    logic expire;

    assign querying = (state_reg == WS_REACH_Q) || (state_reg == WS_LINKUP_Q);
    // countdown only runs while reachable, so expiry always moves to querying
    assign expire   = run_reg && (count_reg <= PERIOD_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= WS_UNKNOWN;
            router_reg <= 1'b0;
            run_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            router_reg <= router_next;
            run_reg    <= run_next;
        end
    end

    // countdown value matters only while running and is reloaded on arming
    always_ff @(posedge aclk) begin
        count_reg <= count_next;
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        router_next = router_reg;
        run_next    = run_reg;
        count_next  = count_reg;
        if (fire) begin
            unique case (act)
                ACT_TICK: begin
                    if (expire) begin
                        run_next   = 1'b0;
                        state_next = WS_REACH_Q;
                    end else if (run_reg) begin
                        count_next = count_reg - PERIOD_W'(1);
                    end
                end
                ACT_CREATE: begin
                    state_next  = WS_REACH;
                    router_next = is_router;
                    run_next    = cfg.periodic_enable;
                    count_next  = cfg.recheck_ticks;
                end
                ACT_LINK_UP: begin
                    state_next = WS_LINKUP_Q;
                    run_next   = 1'b0;
                end
                ACT_LINK_DOWN: begin
                    state_next = WS_UNREACH;
                    run_next   = 1'b0;
                end
                ACT_FORCE: begin
                    if (state_reg != WS_UNREACH) begin
                        state_next = WS_REACH_Q;
                        run_next   = 1'b0;
                    end
                end
                ACT_PROBE_OK: begin
                    if (querying) begin
                        state_next  = WS_REACH;
                        router_next = is_router;
                        run_next    = cfg.periodic_enable;
                        count_next  = cfg.recheck_ticks;
                    end
                end
                ACT_PROBE_FAIL: begin
                    if (querying) begin
                        state_next = WS_UNREACH;
                    end
                end
                ACT_RELEASE: begin
                    state_next  = WS_UNKNOWN;
                    router_next = 1'b0;
                    run_next    = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // result of the current request
    always_comb begin
        result = '0;
        unique case (act)
            ACT_TICK: result.start_probe = expire;
            ACT_CREATE: result.cancel_probe = querying;
            ACT_LINK_UP: result.start_probe = (state_reg != WS_LINKUP_Q);
            ACT_LINK_DOWN: begin
                result.cancel_probe       = querying;
                result.notify_unreachable = (state_reg != WS_UNREACH);
            end
            ACT_FORCE: begin
                result.start_probe = (state_reg != WS_UNREACH) && (state_reg != WS_REACH_Q);
            end
            ACT_PROBE_OK: begin
                if (querying) begin
                    result.notify_router_change = (router_reg != is_router);
                    result.notify_reachable     = (state_reg == WS_LINKUP_Q);
                    result.after_link_up        = (state_reg == WS_LINKUP_Q);
                end
            end
            ACT_PROBE_FAIL: begin
                result.notify_unreachable    = querying;
                result.notify_permanent_loss = querying;
            end
            ACT_RELEASE: result.cancel_probe = querying;
            default: ;
        endcase
        result.state_now     = state_next;
        result.reachable_now = (state_next == WS_REACH) || (state_next == WS_REACH_Q);
        result.router_now    = router_next;
    end

    `NRW_ASSERT(a_run_only_reach, aclk, aresetn, run_reg |-> state_reg == WS_REACH)
    `NRW_ASSERT(a_cancel_from_query, aclk, aresetn, fire && result.cancel_probe |-> querying)
    `NRW_ASSERT(a_start_enters_query, aclk, aresetn, fire && result.start_probe |=> querying)
    `NRW_ASSERT(a_notify_reach_enters, aclk, aresetn,
        fire && result.notify_reachable |=>
            state_reg == WS_REACH && $past(state_reg) == WS_LINKUP_Q)

endmodule

@@ hw/rtl/neighbor_reachability_watcher_top.sv @@
// Neighbor reachability watcher: one event request in, one result out. An accepted request
// is held in an input register, evaluated against the watcher state in a single pass and
// the result registered once the output is free. A new request can be taken every cycle
// while m_ready keeps up. While a result waits on m_ready the block holds one more request
// and then drops s_ready. Configuration over APB (0x0 periodic_enable, 0x4 recheck_ticks
// in 1 ms ticks) must only be written while the block is idle.
module neighbor_reachability_watcher_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nrw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nrw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nrw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_action,
    input  logic                           s_is_router,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_state_now,
    output logic                           m_reachable_now,
    output logic                           m_router_now,
    output logic                           m_notify_reachable,
    output logic                           m_after_link_up,
    output logic                           m_notify_unreachable,
    output logic                           m_notify_permanent_loss,
    output logic                           m_notify_router_change,
    output logic                           m_start_probe,
    output logic                           m_cancel_probe
);
    import nrw_pkg::*;

    nrw_cfg_t    cfg;
    nrw_result_t core_result;

    logic        in_valid_reg, in_valid_next;
    action_t     in_action_reg;
    logic        in_router_reg;
    logic        out_valid_reg, out_valid_next;
    nrw_result_t out_result_reg;

    logic advance;
    logic fire;
    logic s_take;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_action_reg <= action_t'(s_action);
            in_router_reg <= s_is_router;
        end
        if (fire) begin
            out_result_reg <= core_result;
        end
    end

    nrw_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nrw_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .act       (in_action_reg),
        .is_router (in_router_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    assign m_valid                 = out_valid_reg;
    assign m_state_now             = out_result_reg.state_now;
    assign m_reachable_now         = out_result_reg.reachable_now;
    assign m_router_now            = out_result_reg.router_now;
    assign m_notify_reachable      = out_result_reg.notify_reachable;
    assign m_after_link_up         = out_result_reg.after_link_up;
    assign m_notify_unreachable    = out_result_reg.notify_unreachable;
    assign m_notify_permanent_loss = out_result_reg.notify_permanent_loss;
    assign m_notify_router_change  = out_result_reg.notify_router_change;
    assign m_start_probe           = out_result_reg.start_probe;
    assign m_cancel_probe          = out_result_reg.cancel_probe;

endmodule

@@ verif/tb_neighbor_reachability_watcher_top.sv @@
module tb_neighbor_reachability_watcher_top;

    import nrw_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_PERIODIC_ENABLE = {REG_PERIODIC_ENABLE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_RECHECK_TICKS   = {REG_RECHECK_TICKS, 2'b00};
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX           = '1;
    localparam int                    MAX_REPORTS          = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [2:0]            s_action;
    logic                  s_is_router;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_state_now;
    logic                  m_reachable_now;
    logic                  m_router_now;
    logic                  m_notify_reachable;
    logic                  m_after_link_up;
    logic                  m_notify_unreachable;
    logic                  m_notify_permanent_loss;
    logic                  m_notify_router_change;
    logic                  m_start_probe;
    logic                  m_cancel_probe;

    neighbor_reachability_watcher_top uut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_action                (s_action),
        .s_is_router             (s_is_router),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_state_now             (m_state_now),
        .m_reachable_now         (m_reachable_now),
        .m_router_now            (m_router_now),
        .m_notify_reachable      (m_notify_reachable),
        .m_after_link_up         (m_after_link_up),
        .m_notify_unreachable    (m_notify_unreachable),
        .m_notify_permanent_loss (m_notify_permanent_loss),
        .m_notify_router_change  (m_notify_router_change),
        .m_start_probe           (m_start_probe),
        .m_cancel_probe          (m_cancel_probe)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // watcher model: configuration copy and neighbor state
    logic                cfg_periodic;
    logic [PERIOD_W-1:0] cfg_period;
    watch_state_t        nbr_state;
    logic                nbr_router;
    logic [PERIOD_W-1:0] recheck_left;
    logic                recheck_on;
    nrw_result_t         step_out;

    nrw_result_t watch_results_due[$];

    int  mismatches;
    int  n_events;
    int  n_results;
    int  n_settings;
    int  n_expiries;
    int  n_notify;
    bit  tx_idle;
    bit  rx_idle;
    bit  rx_hold;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_probing();
        return nbr_state == WS_REACH_Q || nbr_state == WS_LINKUP_Q;
    endfunction

    // state change with its side effects; a move to the current state is a no-op
    function automatic void enter_state(watch_state_t nxt, bit from_timer);
        watch_state_t prev;
        prev = nbr_state;
        if (prev == nxt)
            return;
        nbr_state = nxt;
        if (prev == WS_REACH && !from_timer)
            recheck_on = 1'b0;
        case (nxt)
            WS_REACH: begin
                if (prev == WS_UNREACH || prev == WS_LINKUP_Q) begin
                    step_out.notify_reachable = 1'b1;
                    step_out.after_link_up    = (prev == WS_LINKUP_Q);
                end
                if (cfg_periodic) begin
                    recheck_on   = 1'b1;
                    recheck_left = cfg_period;
                end
            end
            WS_UNREACH: begin
                step_out.notify_unreachable = 1'b1;
            end
            WS_REACH_Q, WS_LINKUP_Q: begin
                step_out.start_probe = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void cancel_pending_probe();
        if (is_probing())
            step_out.cancel_probe = 1'b1;
    endfunction

    function automatic nrw_result_t compute_watch_result(action_t act, logic isr);
        step_out = '0;
        case (act)
            ACT_TICK: begin
                if (recheck_on) begin
                    if (recheck_left <= 1) begin
                        recheck_on   = 1'b0;
                        recheck_left = '0;
                        n_expiries++;
                        enter_state(WS_REACH_Q, 1'b1);
                    end else begin
                        recheck_left = recheck_left - 1'b1;
                    end
                end
            end
            ACT_CREATE: begin
                cancel_pending_probe();
                nbr_state    = WS_UNKNOWN;
                recheck_on   = 1'b0;
                recheck_left = '0;
                nbr_router   = isr;
                enter_state(WS_REACH, 1'b0);
            end
            ACT_LINK_UP: begin
                enter_state(WS_LINKUP_Q, 1'b0);
            end
            ACT_LINK_DOWN: begin
                cancel_pending_probe();
                enter_state(WS_UNREACH, 1'b0);
            end
            ACT_FORCE: begin
                if (nbr_state != WS_UNREACH)
                    enter_state(WS_REACH_Q, 1'b0);
            end
            ACT_PROBE_OK: begin
                if (is_probing()) begin
                    if (nbr_router != isr)
                        step_out.notify_router_change = 1'b1;
                    nbr_router = isr;
                    enter_state(WS_REACH, 1'b0);
                end
            end
            ACT_PROBE_FAIL: begin
                if (is_probing()) begin
                    enter_state(WS_UNREACH, 1'b0);
                    step_out.notify_permanent_loss = 1'b1;
                end
            end
            default: begin
                cancel_pending_probe();
                enter_state(WS_UNKNOWN, 1'b0);
                nbr_router   = 1'b0;
                recheck_on   = 1'b0;
                recheck_left = '0;
            end
        endcase
        step_out.state_now     = nbr_state;
        step_out.reachable_now = (nbr_state == WS_REACH || nbr_state == WS_REACH_Q);
        step_out.router_now    = nbr_router;
        if (step_out.notify_reachable)
            n_notify++;
        return step_out;
    endfunction

    // request side: predict on every accepted request
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            watch_results_due.push_back(compute_watch_result(action_t'(s_action), s_is_router));
            n_events++;
        end
    end

    function automatic void check_field(string fname, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         n_results, fname, want, got);
        end
    endfunction

    function automatic void check_bit(string fname, logic want, logic got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         n_results, fname, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        nrw_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (watch_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with state %0d arrived with nothing outstanding",
                             m_state_now);
            end else begin
                want = watch_results_due.pop_front();
                check_field("state_now", want.state_now, m_state_now);
                check_bit("reachable_now", want.reachable_now, m_reachable_now);
                check_bit("router_now", want.router_now, m_router_now);
                check_bit("notify_reachable", want.notify_reachable, m_notify_reachable);
                check_bit("after_link_up", want.after_link_up, m_after_link_up);
                check_bit("notify_unreachable", want.notify_unreachable,
                          m_notify_unreachable);
                check_bit("notify_permanent_loss", want.notify_permanent_loss,
                          m_notify_permanent_loss);
                check_bit("notify_router_change", want.notify_router_change,
                          m_notify_router_change);
                check_bit("start_probe", want.start_probe, m_start_probe);
                check_bit("cancel_probe", want.cancel_probe, m_cancel_probe);
            end
            n_results++;
        end
    end

    // result side ready: random stalls, or held low while rx_hold is set
    initial begin : result_ready_gen
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    task automatic hold_results(int cycles);
        rx_hold = 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold = 1'b0;
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_event(action_t act, logic isr);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_is_router <= isr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (watch_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PERIODIC_ENABLE)
            cfg_periodic = data[0];
        else
            cfg_period = data[PERIOD_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_config(logic en, logic [PERIOD_W-1:0] period);
        wait_idle();
        write_reg(ADDR_PERIODIC_ENABLE, APB_DATA_W'(en));
        write_reg(ADDR_RECHECK_TICKS, APB_DATA_W'(period));
        n_settings++;
    endtask

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ACT_TICK;
        if (r < 40) return ACT_CREATE;
        if (r < 50) return ACT_LINK_UP;
        if (r < 60) return ACT_LINK_DOWN;
        if (r < 70) return ACT_FORCE;
        if (r < 82) return ACT_PROBE_OK;
        if (r < 92) return ACT_PROBE_FAIL;
        return ACT_RELEASE;
    endfunction

    function automatic logic rand_bit();
        return logic'($urandom_range(0, 1));
    endfunction

    // create, run the countdown, then answer or break the probe
    task automatic run_lifecycle();
        send_event(ACT_CREATE, rand_bit());
        repeat ($urandom_range(0, 10)) send_event(ACT_TICK, rand_bit());
        case ($urandom_range(0, 4))
            0: begin
                send_event(ACT_FORCE, rand_bit());
                send_event(ACT_PROBE_OK, rand_bit());
            end
            1: send_event(ACT_PROBE_OK, rand_bit());
            2: begin
                send_event(ACT_PROBE_FAIL, rand_bit());
                send_event(ACT_LINK_UP, rand_bit());
                send_event($urandom_range(0, 1) ? ACT_PROBE_OK : ACT_PROBE_FAIL, rand_bit());
            end
            3: begin
                send_event(ACT_LINK_DOWN, rand_bit());
                send_event(ACT_LINK_UP, rand_bit());
                send_event(ACT_PROBE_OK, rand_bit());
            end
            default: send_event(pick_action(), rand_bit());
        endcase
        repeat ($urandom_range(0, 4)) send_event(ACT_TICK, rand_bit());
        if ($urandom_range(0, 2) == 0)
            send_event(ACT_RELEASE, rand_bit());
    endtask

    task automatic random_events(int count);
        int stop_at;
        stop_at = n_events + count;
        while (n_events < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_idle = rand_bit();
                rx_idle = rand_bit();
            end
            if ($urandom_range(0, 9) < 7)
                run_lifecycle();
            else
                send_event(pick_action(), rand_bit());
        end
    endtask

    task automatic test_directed();
        set_config(1'b1, PERIOD_W'(2));
        send_event(ACT_TICK, 1'b1);
        send_event(ACT_PROBE_OK, 1'b1);
        send_event(ACT_PROBE_FAIL, 1'b0);
        send_event(ACT_FORCE, 1'b0);
        send_event(ACT_FORCE, 1'b1);
        send_event(ACT_PROBE_OK, 1'b1);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_PROBE_FAIL, 1'b1);
        send_event(ACT_FORCE, 1'b1);
        send_event(ACT_PROBE_OK, 1'b0);
        send_event(ACT_LINK_UP, 1'b1);
        send_event(ACT_LINK_UP, 1'b0);
        send_event(ACT_PROBE_OK, 1'b0);
        send_event(ACT_LINK_DOWN, 1'b1);
        send_event(ACT_CREATE, 1'b1);
        send_event(ACT_CREATE, 1'b0);
        send_event(ACT_FORCE, 1'b0);
        send_event(ACT_CREATE, 1'b1);
        send_event(ACT_LINK_UP, 1'b0);
        send_event(ACT_LINK_DOWN, 1'b0);
        send_event(ACT_RELEASE, 1'b0);
        send_event(ACT_LINK_DOWN, 1'b1);
        send_event(ACT_RELEASE, 1'b1);
        send_event(ACT_FORCE, 1'b1);
        send_event(ACT_RELEASE, 1'b1);
    endtask

    task automatic test_periodic_off();
        set_config(1'b0, PERIOD_W'(3));
        send_event(ACT_CREATE, 1'b1);
        repeat (5) send_event(ACT_TICK, 1'b0);
        send_event(ACT_FORCE, 1'b0);
        send_event(ACT_PROBE_OK, 1'b1);
        repeat (4) send_event(ACT_TICK, 1'b1);
        send_event(ACT_RELEASE, 1'b0);
    endtask

    task automatic test_period_extremes();
        // enable only: the countdown loads the period written before
        wait_idle();
        write_reg(ADDR_PERIODIC_ENABLE, APB_DATA_W'(1));
        n_settings++;
        send_event(ACT_CREATE, 1'b0);
        repeat (3) send_event(ACT_TICK, 1'b1);
        send_event(ACT_RELEASE, 1'b0);
        // zero period behaves like one
        set_config(1'b1, '0);
        send_event(ACT_CREATE, 1'b1);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_PROBE_OK, 1'b1);
        send_event(ACT_TICK, 1'b0);
        set_config(1'b1, PERIOD_W'(1));
        send_event(ACT_CREATE, 1'b0);
        send_event(ACT_TICK, 1'b0);
        send_event(ACT_PROBE_FAIL, 1'b0);
        send_event(ACT_TICK, 1'b1);
        set_config(1'b1, PERIOD_MAX);
        send_event(ACT_CREATE, 1'b1);
        repeat (4) send_event(ACT_TICK, 1'b0);
        send_event(ACT_FORCE, 1'b0);
        send_event(ACT_PROBE_OK, 1'b0);
        send_event(ACT_RELEASE, 1'b1);
    endtask

    task automatic test_random();
        set_config(1'b1, PERIOD_W'($urandom_range(1, 6)));
        random_events(450);
        set_config(1'b0, PERIOD_W'($urandom_range(1, 6)));
        random_events(400);
        set_config(1'b1, '0);
        random_events(400);
        set_config(1'b1, PERIOD_W'($urandom_range(1, 40)));
        random_events(450);
        set_config(1'b1, PERIOD_W'($urandom_range(1, 6)));
        random_events(200);
    endtask

    // results held back while requests keep coming, so the input stalls
    task automatic test_backpressure();
        wait_idle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        fork
            hold_results(80);
            repeat (60) send_event(pick_action(), rand_bit());
        join
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_events(100);
    endtask

    initial begin
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_action     = ACT_TICK;
        s_is_router  = 1'b0;
        cfg_periodic = 1'b0;
        cfg_period   = RECHECK_TICKS_RESET;
        nbr_state    = WS_UNKNOWN;
        nbr_router   = 1'b0;
        recheck_left = '0;
        recheck_on   = 1'b0;
        mismatches   = 0;
        n_events     = 0;
        n_results    = 0;
        n_settings   = 0;
        n_expiries   = 0;
        n_notify     = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_periodic_off();
        test_period_extremes();
        test_random();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("%0d events checked over %0d register settings, %0d results compared",
                 n_events, n_settings, n_results);
        $display("%0d re-check expiries, %0d reachable notifications, one long result hold-off",
                 n_expiries, n_notify);
        if (mismatches == 0 && watch_results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, watch_results_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout with %0d results outstanding", watch_results_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
